>>> src/hpos_pkg.sv
// Shared types and constants for the head pose smoother.
// Field widths, fixed-point limits, register indexes and sequencer states.
`timescale 1ns / 1ps
`default_nettype none

package hpos_pkg;

  localparam int ANGLE_W   = 16;
  localparam int MOUTH_W   = 16;
  localparam int MEAN_XZ_W = 13;
  localparam int MEAN_Y_W  = 12;
  localparam int CLASS_W   = 2;
  localparam int STEPS_W   = 5;
  localparam int OFFSET_W  = 14;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int WINDOW_DEPTH_DEF = 32;
  localparam int START_COUNT      = 8;
  localparam int ENTRY_W          = 2 * MEAN_XZ_W + MEAN_Y_W;

  localparam int QUOT_W = 12;
  localparam int QCNT_W = 4;
  localparam int CALC_W = 19;

  localparam logic signed [CALC_W-1:0] HALF_TURN    = 19'sd23040;
  localparam logic signed [CALC_W-1:0] QUARTER_TURN = 19'sd11520;
  localparam logic signed [CALC_W-1:0] LIMIT_XZ     = 19'sd3840;
  localparam logic signed [CALC_W-1:0] LIMIT_Y      = 19'sd1920;

  localparam logic [MOUTH_W-1:0] MOUTH_OPEN_MIN = 16'd3277;
  localparam logic [MOUTH_W-1:0] MOUTH_WIDE_MIN = 16'd7373;

  localparam logic [CLASS_W-1:0] MOUTH_CLOSED = 2'd0;
  localparam logic [CLASS_W-1:0] MOUTH_OPEN   = 2'd1;
  localparam logic [CLASS_W-1:0] MOUTH_WIDE   = 2'd2;

  localparam logic [STEPS_W-1:0] SMOOTH_STEPS_RST = 5'd8;

  typedef enum logic [1:0] {
    REG_SMOOTH_STEPS,
    REG_X_OFFSET,
    REG_Y_OFFSET,
    REG_Z_OFFSET
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_DROP,
    ST_APPEND,
    ST_LOAD,
    ST_STEP,
    ST_STORE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> src/hpos_in_if.sv
// Input channel of the head pose smoother: one tracking sample per item.
// Depends on hpos_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hpos_in_if import hpos_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_x;
  logic signed [ANGLE_W-1:0] angle_y;
  logic signed [ANGLE_W-1:0] angle_z;
  logic        [MOUTH_W-1:0] mouth_level;

  modport source (output valid, angle_x, angle_y, angle_z, mouth_level, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, mouth_level, output ready);
endinterface

`default_nettype wire

>>> src/hpos_out_if.sv
// Output channel of the head pose smoother: window means and mouth class.
// Depends on hpos_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hpos_out_if import hpos_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [MEAN_XZ_W-1:0] mean_x;
  logic signed [MEAN_Y_W-1:0]  mean_y;
  logic signed [MEAN_XZ_W-1:0] mean_z;
  logic        [CLASS_W-1:0]   mouth_class;

  modport source (output valid, mean_x, mean_y, mean_z, mouth_class, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, mouth_class, output ready);
endinterface

`default_nettype wire

>>> src/hpos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hpos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/head_pose_offset_clamp_smoother.sv
// Head pose smoother: remap, offset and clamp each sample, then average a sliding window.
// Depends on hpos_pkg, hpos_in_if, hpos_out_if and hpos_ram.
//
// One sample is taken at a time; input ready stays low until the sample's
// work is done. Each window entry that is dropped adds a pass through the
// drop and trim states (usually one per item once the window is at size).
// The work is set by the shared one-bit-per-cycle divider, which runs 12 steps
// for each of the three axes, and by the window memory, whose read data is
// registered. The finished result sits in an output register, so the next
// sample may be taken while it waits to be read. Window entries never written
// read as zero through per-entry valid bits, which reset clears at once; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module head_pose_offset_clamp_smoother import hpos_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  hpos_in_if.sink                in_i,
  hpos_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int IDX_W      = $clog2(WINDOW_DEPTH);
  localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int MAG_W      = QUOT_W + CNT_W;
  localparam int SUM_W      = MAG_W + 1;
  localparam int CMP_W      = (CNT_W > STEPS_W ? CNT_W : STEPS_W) + 1;
  localparam int INIT_COUNT = START_COUNT < WINDOW_DEPTH ? START_COUNT : WINDOW_DEPTH;

  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(INIT_COUNT);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W:0]   SLOT_WRAP = (CNT_W + 1)'(WINDOW_DEPTH);
  localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(QUOT_W - 1);

  function automatic logic signed [CALC_W-1:0] clamp_to(
    input logic signed [CALC_W-1:0] v,
    input logic signed [CALC_W-1:0] lim
  );
    logic signed [CALC_W-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  // configuration registers
  logic        [STEPS_W-1:0]  smooth_steps_q;
  logic signed [OFFSET_W-1:0] x_offset_q, y_offset_q, z_offset_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_steps_q <= SMOOTH_STEPS_RST;
      x_offset_q     <= '0;
      y_offset_q     <= '0;
      z_offset_q     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[APB_AW-1:2]))
        REG_SMOOTH_STEPS: smooth_steps_q <= pwdata[STEPS_W-1:0];
        REG_X_OFFSET:     x_offset_q     <= pwdata[OFFSET_W-1:0];
        REG_Y_OFFSET:     y_offset_q     <= pwdata[OFFSET_W-1:0];
        REG_Z_OFFSET:     z_offset_q     <= pwdata[OFFSET_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[APB_AW-1:2]))
      REG_SMOOTH_STEPS: prdata = APB_DW'(smooth_steps_q);
      REG_X_OFFSET:     prdata = APB_DW'(x_offset_q);
      REG_Y_OFFSET:     prdata = APB_DW'(y_offset_q);
      REG_Z_OFFSET:     prdata = APB_DW'(z_offset_q);
      default:          prdata = '0;
    endcase
  end

  // remap, offset and clamp of the incoming sample
  logic signed [CALC_W-1:0] ax_c, ay_c, az_c, px_c, py_c, pz_c;
  logic        [CLASS_W-1:0] cls_c;

  always_comb begin
    ax_c = CALC_W'(in_i.angle_x);
    ay_c = CALC_W'(in_i.angle_y);
    az_c = CALC_W'(in_i.angle_z);
    if (!ax_c[CALC_W-1] && (ax_c != '0)) begin
      px_c = ax_c - HALF_TURN;
    end else begin
      px_c = ax_c + HALF_TURN;
    end
    px_c = clamp_to(px_c + CALC_W'(x_offset_q), LIMIT_XZ);
    py_c = clamp_to(CALC_W'(y_offset_q) - ay_c, LIMIT_Y);
    pz_c = clamp_to(az_c - QUARTER_TURN + CALC_W'(z_offset_q), LIMIT_XZ);
    if (in_i.mouth_level >= MOUTH_WIDE_MIN) begin
      cls_c = MOUTH_WIDE;
    end else if (in_i.mouth_level >= MOUTH_OPEN_MIN) begin
      cls_c = MOUTH_OPEN;
    end else begin
      cls_c = MOUTH_CLOSED;
    end
  end

  // sequencer and datapath registers
  state_e                      state_q, state_d;
  logic        [CNT_W-1:0]     count_q, count_d;
  logic        [IDX_W-1:0]     oldest_q, oldest_d;
  logic signed [SUM_W-1:0]     sum_x_q, sum_x_d, sum_y_q, sum_y_d, sum_z_q, sum_z_d;
  logic        [WINDOW_DEPTH-1:0] valid_q, valid_d;
  logic                        out_valid_q, out_valid_d;
  axis_e                       axis_q, axis_d;

  logic        [ENTRY_W-1:0]   pose_q, pose_d;
  logic        [CLASS_W-1:0]   cls_q, cls_d;
  logic        [QCNT_W-1:0]    qcnt_q, qcnt_d;
  logic        [CNT_W-1:0]     rem_q, rem_d;
  logic        [QUOT_W-1:0]    lo_q, lo_d;
  logic                        neg_q, neg_d;
  logic signed [MEAN_XZ_W-1:0] mean_x_q, mean_x_d, mean_z_q, mean_z_d;
  logic signed [MEAN_Y_W-1:0]  mean_y_q, mean_y_d;
  logic signed [MEAN_XZ_W-1:0] out_x_q, out_x_d, out_z_q, out_z_d;
  logic signed [MEAN_Y_W-1:0]  out_y_q, out_y_d;
  logic        [CLASS_W-1:0]   out_cls_q, out_cls_d;

  logic                        ram_we;
  logic        [IDX_W-1:0]     slot;
  logic        [ENTRY_W-1:0]   ram_rdata, ent;
  logic        [CNT_W:0]       slot_sum, trial, diff;
  logic                        drop_need, ge;
  logic signed [MEAN_XZ_W-1:0] ent_x, ent_z, pose_x, pose_z;
  logic signed [MEAN_Y_W-1:0]  ent_y, pose_y;
  logic signed [SUM_W-1:0]     sum_sel;
  logic        [SUM_W-1:0]     mag;
  logic signed [QUOT_W:0]      quot;

  hpos_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (pose_q),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.mean_x      = out_x_q;
  assign out_o.mean_y      = out_y_q;
  assign out_o.mean_z      = out_z_q;
  assign out_o.mouth_class = out_cls_q;

  always_comb begin
    drop_need = (CMP_W'(count_q) > CMP_W'(smooth_steps_q) + CMP_W'(1)) ||
                (count_q >= CNT_FULL);
    slot_sum  = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
    if (slot_sum >= SLOT_WRAP) begin
      slot = IDX_W'(slot_sum - SLOT_WRAP);
    end else begin
      slot = IDX_W'(slot_sum);
    end

    ent    = valid_q[oldest_q] ? ram_rdata : '0;
    ent_x  = ent[ENTRY_W-1 -: MEAN_XZ_W];
    ent_y  = ent[MEAN_XZ_W +: MEAN_Y_W];
    ent_z  = ent[MEAN_XZ_W-1:0];
    pose_x = pose_q[ENTRY_W-1 -: MEAN_XZ_W];
    pose_y = pose_q[MEAN_XZ_W +: MEAN_Y_W];
    pose_z = pose_q[MEAN_XZ_W-1:0];

    case (axis_q)
      AXIS_X:  sum_sel = sum_x_q;
      AXIS_Y:  sum_sel = sum_y_q;
      AXIS_Z:  sum_sel = sum_z_q;
      default: sum_sel = sum_z_q;
    endcase
    mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

    trial = {rem_q, lo_q[QUOT_W-1]};
    diff  = trial - {1'b0, count_q};
    ge    = (trial >= {1'b0, count_q});
    quot  = neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    sum_z_d     = sum_z_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    axis_d      = axis_q;
    pose_d      = pose_q;
    cls_d       = cls_q;
    qcnt_d      = qcnt_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    neg_d       = neg_q;
    mean_x_d    = mean_x_q;
    mean_y_d    = mean_y_q;
    mean_z_d    = mean_z_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_cls_d   = out_cls_q;
    ram_we      = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          pose_d  = {px_c[MEAN_XZ_W-1:0], py_c[MEAN_Y_W-1:0], pz_c[MEAN_XZ_W-1:0]};
          cls_d   = cls_c;
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        state_d = drop_need ? ST_DROP : ST_APPEND;
      end
      ST_DROP: begin
        sum_x_d  = sum_x_q - SUM_W'(ent_x);
        sum_y_d  = sum_y_q - SUM_W'(ent_y);
        sum_z_d  = sum_z_q - SUM_W'(ent_z);
        oldest_d = (oldest_q == IDX_LAST) ? '0 : oldest_q + IDX_W'(1);
        count_d  = count_q - CNT_W'(1);
        state_d  = ST_TRIM;
      end
      ST_APPEND: begin
        ram_we        = 1'b1;
        valid_d[slot] = 1'b1;
        sum_x_d       = sum_x_q + SUM_W'(pose_x);
        sum_y_d       = sum_y_q + SUM_W'(pose_y);
        sum_z_d       = sum_z_q + SUM_W'(pose_z);
        count_d       = count_q + CNT_W'(1);
        axis_d        = AXIS_X;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        neg_d   = sum_sel[SUM_W-1];
        rem_d   = mag[MAG_W-1:QUOT_W];
        lo_d    = mag[QUOT_W-1:0];
        qcnt_d  = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        lo_d   = {lo_q[QUOT_W-2:0], ge};
        qcnt_d = qcnt_q + QCNT_W'(1);
        if (qcnt_q == QCNT_LAST) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        case (axis_q)
          AXIS_X: begin
            mean_x_d = quot;
            axis_d   = AXIS_Y;
            state_d  = ST_LOAD;
          end
          AXIS_Y: begin
            mean_y_d = quot[MEAN_Y_W-1:0];
            axis_d   = AXIS_Z;
            state_d  = ST_LOAD;
          end
          default: begin
            mean_z_d = quot;
            state_d  = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_x_d     = mean_x_q;
          out_y_d     = mean_y_q;
          out_z_d     = mean_z_q;
          out_cls_d   = cls_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CNT_INIT;
      oldest_q    <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      axis_q      <= AXIS_X;
      qcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      sum_z_q     <= sum_z_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      axis_q      <= axis_d;
      qcnt_q      <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pose_q    <= pose_d;
    cls_q     <= cls_d;
    rem_q     <= rem_d;
    lo_q      <= lo_d;
    neg_q     <= neg_d;
    mean_x_q  <= mean_x_d;
    mean_y_q  <= mean_y_d;
    mean_z_q  <= mean_z_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    out_z_q   <= out_z_d;
    out_cls_q <= out_cls_d;
  end

endmodule

`default_nettype wire

>>> src/hpos_chk.sv
// Port-level checks for the head pose smoother, bound to the top level.
// Depends on hpos_pkg and head_pose_offset_clamp_smoother.
`timescale 1ns / 1ps
`default_nettype none

module hpos_chk import hpos_pkg::*; (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic signed [MEAN_XZ_W-1:0] mean_x_i,
  input wire logic signed [MEAN_Y_W-1:0]  mean_y_i,
  input wire logic signed [MEAN_XZ_W-1:0] mean_z_i,
  input wire logic        [CLASS_W-1:0]   mouth_class_i
);

  localparam logic signed [MEAN_XZ_W-1:0] XZ_MAX = MEAN_XZ_W'(LIMIT_XZ);
  localparam logic signed [MEAN_Y_W-1:0]  Y_MAX  = MEAN_Y_W'(LIMIT_Y);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is still in work");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result raised without a finished item");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> mean_x_i <= XZ_MAX && mean_x_i >= -XZ_MAX &&
                    mean_z_i <= XZ_MAX && mean_z_i >= -XZ_MAX &&
                    mean_y_i <= Y_MAX && mean_y_i >= -Y_MAX)
    else $error("window mean outside clamp limits");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_x_i) &&
      $stable(mean_y_i) && $stable(mean_z_i) && $stable(mouth_class_i))
    else $error("stalled result changed");

endmodule

bind head_pose_offset_clamp_smoother hpos_chk u_hpos_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .mean_x_i      (out_o.mean_x),
  .mean_y_i      (out_o.mean_y),
  .mean_z_i      (out_o.mean_z),
  .mouth_class_i (out_o.mouth_class)
);

`default_nettype wire

>>> tb/hpos_checker.sv
// Scoreboard for the head pose smoother: follows register writes, predicts the
// window means and mouth class of each accepted sample and compares every result.
// Depends on hpos_pkg, hpos_in_if and hpos_out_if.
`timescale 1ns / 1ps

module hpos_checker import hpos_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hpos_in_if                smp_i,
  hpos_out_if               res_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  typedef struct packed {
    logic signed [MEAN_XZ_W-1:0] mean_x;
    logic signed [MEAN_Y_W-1:0]  mean_y;
    logic signed [MEAN_XZ_W-1:0] mean_z;
    logic        [CLASS_W-1:0]   mouth_class;
  } pose_mean_t;

  pose_mean_t mean_q[$];

  logic signed [MEAN_XZ_W-1:0] win_x [WINDOW_DEPTH_DEF];
  logic signed [MEAN_Y_W-1:0]  win_y [WINDOW_DEPTH_DEF];
  logic signed [MEAN_XZ_W-1:0] win_z [WINDOW_DEPTH_DEF];
  int win_len;
  int win_head;
  int sum_x;
  int sum_y;
  int sum_z;

  logic        [STEPS_W-1:0]  steps;
  logic signed [OFFSET_W-1:0] x_ofs;
  logic signed [OFFSET_W-1:0] y_ofs;
  logic signed [OFFSET_W-1:0] z_ofs;

  int n_fail;
  int n_pend;
  int n_checked;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pend;
  assign checked_o    = n_checked;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    n_fail++;
  endtask

  function automatic int clamp_angle(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void drop_oldest();
    sum_x -= win_x[win_head];
    sum_y -= win_y[win_head];
    sum_z -= win_z[win_head];
    win_head = (win_head + 1) % WINDOW_DEPTH_DEF;
    win_len--;
  endfunction

  function automatic pose_mean_t predict_sample(input logic signed [ANGLE_W-1:0] ax,
                                                input logic signed [ANGLE_W-1:0] ay,
                                                input logic signed [ANGLE_W-1:0] az,
                                                input logic [MOUTH_W-1:0] lvl);
    pose_mean_t m;
    int px;
    int py;
    int pz;
    int slot;
    px = (ax > 0) ? int'(ax) - int'(HALF_TURN) : int'(ax) + int'(HALF_TURN);
    py = -int'(ay);
    pz = int'(az) - int'(QUARTER_TURN);
    px = clamp_angle(px + int'(x_ofs), int'(LIMIT_XZ));
    py = clamp_angle(py + int'(y_ofs), int'(LIMIT_Y));
    pz = clamp_angle(pz + int'(z_ofs), int'(LIMIT_XZ));
    while (win_len > 0 && win_len - 1 > int'(steps)) drop_oldest();
    if (win_len >= WINDOW_DEPTH_DEF) drop_oldest();
    slot = (win_head + win_len) % WINDOW_DEPTH_DEF;
    win_x[slot] = MEAN_XZ_W'(px);
    win_y[slot] = MEAN_Y_W'(py);
    win_z[slot] = MEAN_XZ_W'(pz);
    sum_x += px;
    sum_y += py;
    sum_z += pz;
    win_len++;
    m.mean_x = MEAN_XZ_W'(sum_x / win_len);
    m.mean_y = MEAN_Y_W'(sum_y / win_len);
    m.mean_z = MEAN_XZ_W'(sum_z / win_len);
    m.mouth_class = (lvl >= MOUTH_WIDE_MIN) ? MOUTH_WIDE :
                    (lvl >= MOUTH_OPEN_MIN) ? MOUTH_OPEN : MOUTH_CLOSED;
    return m;
  endfunction

  task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    case (reg_idx_e'(addr[APB_AW-1:2]))
      REG_SMOOTH_STEPS: steps = data[STEPS_W-1:0];
      REG_X_OFFSET:     x_ofs = data[OFFSET_W-1:0];
      REG_Y_OFFSET:     y_ofs = data[OFFSET_W-1:0];
      REG_Z_OFFSET:     z_ofs = data[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_result();
    pose_mean_t want;
    if (mean_q.size() == 0) begin
      report_mismatch($sformatf("result with no sample pending: x %0d y %0d z %0d class %0d",
                                res_i.mean_x, res_i.mean_y, res_i.mean_z, res_i.mouth_class));
    end else begin
      want = mean_q[0];
      mean_q.delete(0);
      if (res_i.mean_x !== want.mean_x)
        report_mismatch($sformatf("result %0d mean_x: got %0d, want %0d",
                                  n_checked, res_i.mean_x, want.mean_x));
      if (res_i.mean_y !== want.mean_y)
        report_mismatch($sformatf("result %0d mean_y: got %0d, want %0d",
                                  n_checked, res_i.mean_y, want.mean_y));
      if (res_i.mean_z !== want.mean_z)
        report_mismatch($sformatf("result %0d mean_z: got %0d, want %0d",
                                  n_checked, res_i.mean_z, want.mean_z));
      if (res_i.mouth_class !== want.mouth_class)
        report_mismatch($sformatf("result %0d mouth_class: got %0d, want %0d",
                                  n_checked, res_i.mouth_class, want.mouth_class));
      n_checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH_DEF; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
        win_z[i] = '0;
      end
      win_len   = (START_COUNT < WINDOW_DEPTH_DEF) ? START_COUNT : WINDOW_DEPTH_DEF;
      win_head  = 0;
      sum_x     = 0;
      sum_y     = 0;
      sum_z     = 0;
      steps     = SMOOTH_STEPS_RST;
      x_ofs     = '0;
      y_ofs     = '0;
      z_ofs     = '0;
      mean_q.delete();
      n_fail    = 0;
      n_pend    = 0;
      n_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      if (res_i.valid && res_i.ready) check_result();
      if (smp_i.valid && smp_i.ready)
        mean_q = {mean_q, predict_sample(smp_i.angle_x, smp_i.angle_y, smp_i.angle_z,
                                         smp_i.mouth_level)};
      n_pend = mean_q.size();
    end
  end

endmodule

>>> tb/head_pose_offset_clamp_smoother_tb.sv
// Top of the head pose smoother testbench: clock, reset, sample and register
// stimulus with random back-pressure, and the verdict. Depends on hpos_pkg, the
// channel interfaces, head_pose_offset_clamp_smoother and hpos_checker.
`timescale 1ns / 1ps

module head_pose_offset_clamp_smoother_tb;
  import hpos_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 12;
  localparam int PHASE_SAMPLES = 160;
  localparam int TAIL_CYCLES   = 100;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int n_sent = 0;
  int n_settings = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  hpos_in_if  in_ch ();
  hpos_out_if out_ch ();

  head_pose_offset_clamp_smoother dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hpos_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .smp_i        (in_ch),
    .res_i        (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_sample(input int ax, input int ay, input int az, input int lvl);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.angle_x     <= ANGLE_W'(ax);
    in_ch.angle_y     <= ANGLE_W'(ay);
    in_ch.angle_z     <= ANGLE_W'(az);
    in_ch.mouth_level <= MOUTH_W'(lvl);
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic send_random();
    int ax;
    int ay;
    int az;
    int lvl;
    if ($urandom_range(0, 99) < 65) begin
      ax = int'($urandom_range(0, 5000));
      ax = $urandom_range(0, 1) ? 23040 - ax : ax - 23040;
      ay = int'($urandom_range(0, 5000)) - 2500;
      az = int'($urandom_range(5000, 18000));
    end else begin
      ax = int'($urandom);
      ay = int'($urandom);
      az = int'($urandom);
    end
    lvl = $urandom_range(0, 1) ? int'($urandom_range(0, 9000)) : int'($urandom);
    send_sample(ax, ay, az, lvl);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_e idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input int st, input int xo, input int yo, input int zo);
    wait_drained();
    apb_write(REG_SMOOTH_STEPS, st);
    apb_write(REG_X_OFFSET, xo);
    apb_write(REG_Y_OFFSET, yo);
    apb_write(REG_Z_OFFSET, zo);
    n_settings++;
  endtask

  initial begin
    int st_tab [8];
    int xo_tab [8];
    int yo_tab [8];
    int zo_tab [8];
    st_tab = '{31, 0, 20, 1, 31, 3, 8, 12};
    xo_tab = '{8191, -8192, -5760, 5760, -8192, 0, 1000, -300};
    yo_tab = '{-8192, 8191, 5760, -5760, 8191, 0, -1000, 300};
    zo_tab = '{8191, -8192, -5760, 5760, -8192, 0, 2500, -2500};

    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.angle_x     = '0;
    in_ch.angle_y     = '0;
    in_ch.angle_z     = '0;
    in_ch.mouth_level = '0;
    out_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: window starts with eight zero poses and grows to ten
    n_settings = 1;
    send_sample(0, 0, 0, 0);
    send_sample(1, 0, 11520, 3276);
    send_sample(-1, 1920, 11520, 3277);
    send_sample(23040, -1920, 15360, 7372);
    send_sample(-23040, 1921, 7680, 7373);
    send_sample(32767, -32768, 32767, 65535);
    send_sample(-32768, 32767, -32768, 0);
    send_sample(19200, -1921, 7679, 32768);
    send_sample(-19200, 100, 15361, 1);
    send_sample(19199, -100, 15360, 3277);
    send_sample(-19199, 5000, 0, 7373);
    send_sample(21000, -500, 12000, 5000);
    send_sample(-21000, 500, 11000, 65534);
    send_sample(22000, 0, 11520, 3276);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 8)
        apply_setting(st_tab[p], xo_tab[p], yo_tab[p], zo_tab[p]);
      else
        apply_setting(int'($urandom_range(0, 31)), int'($urandom_range(0, 16383)) - 8192,
                      int'($urandom_range(0, 16383)) - 8192,
                      int'($urandom_range(0, 16383)) - 8192);
      tx_idle_pct = (p < 4) ? 38 : (p < 8) ? 67 : 0;
      rx_idle_pct = (p < 4) ? 67 : (p < 8) ? 38 : 0;
      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d samples under %0d register settings, %0d results checked.",
             n_sent, n_settings, checked);
    $display("Window sizes 2 to 32, offset and angle extremes, all mouth classes covered.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
